// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, off while reset is held
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent check that also holds during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/crtc_vt_pkg.sv =====
package crtc_vt_pkg;

  localparam int ROW_W      = 7;
  localparam int RASTER_W   = 5;
  localparam int ADDR_W     = 14;
  localparam int SYNC_W     = 4;
  localparam int STATUS_W   = 8;
  localparam int CFG_DATA_W = 14;
  localparam int CFG_IDX_W  = 3;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_VERTICAL_TOTAL     = 3'd0;
  localparam cfg_idx_t CFG_VERTICAL_ADJUST    = 3'd1;
  localparam cfg_idx_t CFG_VERTICAL_DISPLAYED = 3'd2;
  localparam cfg_idx_t CFG_VSYNC_POSITION     = 3'd3;
  localparam cfg_idx_t CFG_MAX_RASTER         = 3'd4;
  localparam cfg_idx_t CFG_VSYNC_WIDTH        = 3'd5;
  localparam cfg_idx_t CFG_START_ADDRESS      = 3'd6;

  localparam logic [RASTER_W-1:0] RASTER_STEP = 5'd2;
  localparam logic [STATUS_W-1:0] STATUS_BASE = 8'h1f;
  localparam int STATUS_RASTER_ZERO_BIT = 7;
  localparam int STATUS_BELOW_MAX_BIT   = 5;

  typedef struct packed {
    logic [ROW_W-1:0]    vertical_total;
    logic [RASTER_W-1:0] vertical_adjust;
    logic [ROW_W-1:0]    vertical_displayed;
    logic [ROW_W-1:0]    vsync_position;
    logic [RASTER_W-1:0] max_raster;
    logic [SYNC_W-1:0]   vsync_width;
    logic [ADDR_W-1:0]   start_address;
  } cfg_t;

  typedef struct packed {
    logic [RASTER_W-1:0] raster_address;
    logic [ROW_W-1:0]    row_count;
    logic [ADDR_W-1:0]   line_start_address;
    logic                vsync_active;
    logic                display_active;
    logic                adjust_active;
    logic                odd_frame;
    logic [STATUS_W-1:0] status_two;
  } result_t;

endpackage

// ===== sv/crtc_vt_if.sv =====
interface crtc_vt_in_if;
  import crtc_vt_pkg::*;

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] display_end_address;

  modport source (output valid, output display_end_address, input ready);
  modport sink   (input valid, input display_end_address, output ready);
endinterface

interface crtc_vt_out_if;
  import crtc_vt_pkg::*;

  logic                valid;
  logic                ready;
  logic [RASTER_W-1:0] raster_address;
  logic [ROW_W-1:0]    row_count;
  logic [ADDR_W-1:0]   line_start_address;
  logic                vsync_active;
  logic                display_active;
  logic                adjust_active;
  logic                odd_frame;
  logic [STATUS_W-1:0] status_two;

  modport source (
    output valid, output raster_address, output row_count, output line_start_address,
    output vsync_active, output display_active, output adjust_active, output odd_frame,
    output status_two, input ready
  );
  modport sink (
    input valid, input raster_address, input row_count, input line_start_address,
    input vsync_active, input display_active, input adjust_active, input odd_frame,
    input status_two, output ready
  );
endinterface

// ===== sv/crtc_vt_regs.sv =====
module crtc_vt_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  crtc_vt_pkg::cfg_idx_t               cfg_index,
  input  logic [crtc_vt_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output crtc_vt_pkg::cfg_t                   cfg
);
  import crtc_vt_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_VERTICAL_TOTAL:     cfg_r.vertical_total     <= cfg_wdata[ROW_W-1:0];
        CFG_VERTICAL_ADJUST:    cfg_r.vertical_adjust    <= cfg_wdata[RASTER_W-1:0];
        CFG_VERTICAL_DISPLAYED: cfg_r.vertical_displayed <= cfg_wdata[ROW_W-1:0];
        CFG_VSYNC_POSITION:     cfg_r.vsync_position     <= cfg_wdata[ROW_W-1:0];
        CFG_MAX_RASTER:         cfg_r.max_raster         <= cfg_wdata[RASTER_W-1:0];
        CFG_VSYNC_WIDTH:        cfg_r.vsync_width        <= cfg_wdata[SYNC_W-1:0];
        CFG_START_ADDRESS:      cfg_r.start_address      <= cfg_wdata[ADDR_W-1:0];
        default:                cfg_r                    <= cfg_r;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== sv/crtc_vt_step.sv =====
`include "assert_macros.svh"

module crtc_vt_step (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            step_go,
  input  logic [crtc_vt_pkg::ADDR_W-1:0]  display_end_address,
  input  crtc_vt_pkg::cfg_t               cfg,
  output crtc_vt_pkg::result_t            res
);
  import crtc_vt_pkg::*;

  logic [RASTER_W-1:0] raster_r, raster_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;
  logic [ADDR_W-1:0]   address_saved_r, address_saved_nxt;
  logic [ADDR_W-1:0]   address_now;
  logic [SYNC_W-1:0]   sync_count_r, sync_count_nxt;
  logic                sync_running_r, sync_running_nxt;
  logic                last_raster_r, last_raster_nxt;
  logic                total_r, total_nxt;
  logic                adjust_r, adjust_nxt;
  logic                display_r, display_nxt;
  logic                parity_r, parity_nxt;
  logic                new_frame;
  logic [STATUS_W-1:0] status;

  always_comb begin
    address_saved_nxt = last_raster_r ? display_end_address : address_saved_r;
    raster_nxt        = RASTER_W'(raster_r + RASTER_STEP);
    sync_count_nxt    = sync_count_r;
    sync_running_nxt  = sync_running_r;
    row_nxt           = row_r;
    last_raster_nxt   = last_raster_r;
    total_nxt         = total_r;
    adjust_nxt        = adjust_r;
    display_nxt       = display_r;
    parity_nxt        = parity_r;
    new_frame         = 1'b0;

    if (sync_running_r) begin
      sync_count_nxt = SYNC_W'(sync_count_r + 1'b1);
      if (sync_count_nxt == cfg.vsync_width) begin
        sync_count_nxt   = '0;
        sync_running_nxt = 1'b0;
      end
    end

    // row advance after the last raster line
    if (last_raster_r) begin
      last_raster_nxt = 1'b0;
      raster_nxt      = '0;
      if (!total_r) begin
        row_nxt = ROW_W'(row_r + 1'b1);
      end
    end

    if (adjust_nxt && (raster_nxt >= cfg.vertical_adjust)) begin
      adjust_nxt = 1'b0;
      new_frame  = 1'b1;
    end

    if (total_r) begin
      total_nxt  = 1'b0;
      parity_nxt = !parity_r;
      if (cfg.vertical_adjust != '0) begin
        adjust_nxt = 1'b1;
      end else begin
        new_frame = 1'b1;
      end
    end

    address_now = address_saved_nxt;
    if (new_frame) begin
      address_now       = cfg.start_address;
      address_saved_nxt = cfg.start_address;
      raster_nxt        = '0;
      row_nxt           = '0;
      display_nxt       = 1'b1;
    end

    if (!adjust_nxt && (raster_nxt >= cfg.max_raster)) begin
      if (row_nxt >= cfg.vertical_total) begin
        total_nxt = 1'b1;
      end
      last_raster_nxt = 1'b1;
    end

    // display off and sync start on the first raster of a row
    if (raster_nxt == '0) begin
      if (row_nxt == cfg.vertical_displayed) begin
        display_nxt = 1'b0;
      end
      if ((row_nxt == cfg.vsync_position) && !sync_running_nxt) begin
        sync_running_nxt = 1'b1;
        sync_count_nxt   = '0;
      end
    end

    status = STATUS_BASE;
    status[STATUS_RASTER_ZERO_BIT] = (raster_nxt == '0);
    status[STATUS_BELOW_MAX_BIT]   = (raster_nxt < cfg.max_raster);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raster_r        <= '0;
      row_r           <= '0;
      address_saved_r <= '0;
      sync_count_r    <= '0;
      sync_running_r  <= 1'b0;
      last_raster_r   <= 1'b0;
      total_r         <= 1'b0;
      adjust_r        <= 1'b0;
      display_r       <= 1'b0;
      parity_r        <= 1'b0;
    end else if (step_go) begin
      raster_r        <= raster_nxt;
      row_r           <= row_nxt;
      address_saved_r <= address_saved_nxt;
      sync_count_r    <= sync_count_nxt;
      sync_running_r  <= sync_running_nxt;
      last_raster_r   <= last_raster_nxt;
      total_r         <= total_nxt;
      adjust_r        <= adjust_nxt;
      display_r       <= display_nxt;
      parity_r        <= parity_nxt;
    end
  end

  always_comb begin
    res.raster_address     = raster_nxt;
    res.row_count          = row_nxt;
    res.line_start_address = address_now;
    res.vsync_active       = sync_running_nxt;
    res.display_active     = display_nxt;
    res.adjust_active      = adjust_nxt;
    res.odd_frame          = parity_nxt;
    res.status_two         = status;
  end

  `ASSERT_CLK(a_row_step_zero_raster, clk, rst_n, step_go && last_raster_r |=> raster_r == '0, "raster not cleared after last raster line")
  `ASSERT_ALWAYS(a_idle_sync_count, clk, !sync_running_r |-> sync_count_r == '0, "sync counter nonzero while stopped")
  `ASSERT_ALWAYS(a_total_not_adjust, clk, total_r |-> !adjust_r, "vertical total flagged inside adjust lines")

endmodule

// ===== sv/crtc_vertical_line_timing_core.sv =====
// channel | dir | payload                                  | handshake
// in_ch   | in  | display_end_address                      | valid and ready
// out_ch  | out | raster, row, address, flags, status_two  | valid and ready
// cfg     | in  | cfg_index, cfg_wdata                     | cfg_we only
// one beat per cycle sustained while out_ch is ready; a result passes the input register, then the result register
// the line-state registers feed back to themselves through the combinational step logic
// synchronous active-low reset clears timing state, config registers and valids
// an output stall holds the result register, then the input register, then in_ch
`include "assert_macros.svh"

module crtc_vertical_line_timing_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  crtc_vt_pkg::cfg_idx_t              cfg_index,
  input  logic [crtc_vt_pkg::CFG_DATA_W-1:0] cfg_wdata,
  crtc_vt_in_if.sink                         in_ch,
  crtc_vt_out_if.source                      out_ch
);
  import crtc_vt_pkg::*;

  cfg_t              cfg;
  result_t           res;
  result_t           out_res_r;
  logic              s1_valid_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic              out_valid_r;
  logic              go;
  logic              in_fire;

  assign go          = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || go;
  assign in_fire     = in_ch.valid && in_ch.ready;

  crtc_vt_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  crtc_vt_step u_step (
    .clk                 (clk),
    .rst_n               (rst_n),
    .step_go             (go),
    .display_end_address (s1_addr_r),
    .cfg                 (cfg),
    .res                 (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (go) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_addr_r <= in_ch.display_end_address;
    end
    if (go) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.raster_address     = out_res_r.raster_address;
  assign out_ch.row_count          = out_res_r.row_count;
  assign out_ch.line_start_address = out_res_r.line_start_address;
  assign out_ch.vsync_active       = out_res_r.vsync_active;
  assign out_ch.display_active     = out_res_r.display_active;
  assign out_ch.adjust_active      = out_res_r.adjust_active;
  assign out_ch.odd_frame          = out_res_r.odd_frame;
  assign out_ch.status_two         = out_res_r.status_two;

  `ASSERT_CLK(a_in_beat_held, clk, rst_n, in_fire |=> s1_valid_r, "accepted beat missing from input register")
  `ASSERT_CLK(a_step_to_out, clk, rst_n, go |=> out_valid_r, "stepped line missing from result register")
  `ASSERT_CLK(a_waiting_beat_kept, clk, rst_n, s1_valid_r && !go |=> s1_valid_r, "waiting beat dropped")

endmodule

// ===== tb/crtc_vt_line_checker.sv =====
module crtc_vt_line_checker
  import crtc_vt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  cfg_idx_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  crtc_vt_in_if                 in_ch,
  crtc_vt_out_if                out_ch,
  output int                    mismatches,
  output int                    outstanding,
  output int                    lines_checked,
  output int                    frames_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  cfg_t regs;

  logic [RASTER_W-1:0] rast;
  logic [ROW_W-1:0]    row_q;
  logic [ADDR_W-1:0]   addr_now;
  logic [ADDR_W-1:0]   addr_saved;
  logic [SYNC_W-1:0]   sync_cnt;
  logic                sync_on;
  logic                last_rast;
  logic                total_hit;
  logic                adj_on;
  logic                disp_on;
  logic                par;

  result_t line_q[$];
  int      err_cnt = 0;
  int      check_cnt = 0;
  int      frame_cnt = 0;

  function automatic void row_checks();
    if (row_q == regs.vertical_displayed && rast == '0) disp_on = 1'b0;
    if (row_q == regs.vsync_position && rast == '0 && !sync_on) begin
      sync_cnt = '0;
      sync_on  = 1'b1;
    end
  endfunction

  function automatic void frame_restart();
    addr_now   = regs.start_address;
    addr_saved = addr_now;
    rast       = '0;
    row_q      = '0;
    disp_on    = 1'b1;
    row_checks();
  endfunction

  function automatic result_t line_step(input logic [ADDR_W-1:0] end_addr);
    result_t             r;
    logic [STATUS_W-1:0] st;
    // next row start is latched on the last raster of a row
    if (last_rast) addr_saved = end_addr;
    rast = rast + RASTER_STEP;
    if (sync_on) begin
      sync_cnt = sync_cnt + 1'b1;
      if (sync_cnt == regs.vsync_width) begin
        sync_cnt = '0;
        sync_on  = 1'b0;
      end
    end
    if (last_rast) begin
      last_rast = 1'b0;
      rast      = '0;
      if (!total_hit) row_q = row_q + 1'b1;
    end
    addr_now = addr_saved;
    if (adj_on && rast >= regs.vertical_adjust) begin
      adj_on = 1'b0;
      frame_restart();
    end
    if (total_hit) begin
      total_hit = 1'b0;
      par       = !par;
      frame_cnt++;
      if (regs.vertical_adjust != '0) adj_on = 1'b1;
      else frame_restart();
    end
    if (!adj_on && rast >= regs.max_raster) begin
      if (row_q >= regs.vertical_total) total_hit = 1'b1;
      last_rast = 1'b1;
    end
    row_checks();
    st = STATUS_BASE;
    if (rast == '0) st[STATUS_RASTER_ZERO_BIT] = 1'b1;
    if (rast < regs.max_raster) st[STATUS_BELOW_MAX_BIT] = 1'b1;
    r.raster_address     = rast;
    r.row_count          = row_q;
    r.line_start_address = addr_now;
    r.vsync_active       = sync_on;
    r.display_active     = disp_on;
    r.adjust_active      = adj_on;
    r.odd_frame          = par;
    r.status_two         = st;
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      err_cnt++;
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst_n) begin
      regs       = '0;
      rast       = '0;
      row_q      = '0;
      addr_now   = '0;
      addr_saved = '0;
      sync_cnt   = '0;
      sync_on    = 1'b0;
      last_rast  = 1'b0;
      total_hit  = 1'b0;
      adj_on     = 1'b0;
      disp_on    = 1'b0;
      par        = 1'b0;
      line_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_VERTICAL_TOTAL:     regs.vertical_total     = cfg_wdata[ROW_W-1:0];
          CFG_VERTICAL_ADJUST:    regs.vertical_adjust    = cfg_wdata[RASTER_W-1:0];
          CFG_VERTICAL_DISPLAYED: regs.vertical_displayed = cfg_wdata[ROW_W-1:0];
          CFG_VSYNC_POSITION:     regs.vsync_position     = cfg_wdata[ROW_W-1:0];
          CFG_MAX_RASTER:         regs.max_raster         = cfg_wdata[RASTER_W-1:0];
          CFG_VSYNC_WIDTH:        regs.vsync_width        = cfg_wdata[SYNC_W-1:0];
          CFG_START_ADDRESS:      regs.start_address      = cfg_wdata[ADDR_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        line_q.push_back(line_step(in_ch.display_end_address));
      if (out_ch.valid && out_ch.ready) begin
        got.raster_address     = out_ch.raster_address;
        got.row_count          = out_ch.row_count;
        got.line_start_address = out_ch.line_start_address;
        got.vsync_active       = out_ch.vsync_active;
        got.display_active     = out_ch.display_active;
        got.adjust_active      = out_ch.adjust_active;
        got.odd_frame          = out_ch.odd_frame;
        got.status_two         = out_ch.status_two;
        if (line_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result beat, expected none, got 0x%0h", $time, got);
        end else begin
          want = line_q.pop_front();
          check_cnt++;
          check_field("raster_address", 32'(want.raster_address),
                      32'(got.raster_address));
          check_field("row_count", 32'(want.row_count), 32'(got.row_count));
          check_field("line_start_address", 32'(want.line_start_address),
                      32'(got.line_start_address));
          check_field("vsync_active", 32'(want.vsync_active), 32'(got.vsync_active));
          check_field("display_active", 32'(want.display_active),
                      32'(got.display_active));
          check_field("adjust_active", 32'(want.adjust_active),
                      32'(got.adjust_active));
          check_field("odd_frame", 32'(want.odd_frame), 32'(got.odd_frame));
          check_field("status_two", 32'(want.status_two), 32'(got.status_two));
        end
      end
    end
    outstanding   <= line_q.size();
    mismatches    <= err_cnt;
    lines_checked <= check_cnt;
    frames_seen   <= frame_cnt;
  end

endmodule

// ===== tb/testbench.sv =====
module testbench;
  import crtc_vt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TARGET_LINES = 950;
  localparam int CYCLE_LIMIT  = 400000;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  cfg_idx_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  crtc_vt_in_if  line_in();
  crtc_vt_out_if line_out();

  int mismatch_cnt;
  int lines_pending;
  int lines_checked;
  int frame_ends;

  int          cycle_cnt = 0;
  bit          gaps_on;
  int unsigned burst_left;
  int unsigned pace_mode = 0;
  int unsigned pace_left = 0;

  crtc_vertical_line_timing_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (line_in),
    .out_ch    (line_out)
  );

  crtc_vt_line_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_ch         (line_in),
    .out_ch        (line_out),
    .mismatches    (mismatch_cnt),
    .outstanding   (lines_pending),
    .lines_checked (lines_checked),
    .frames_seen   (frame_ends)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("crtc_vertical_line_timing_core: mismatch");
      $finish;
    end
  end

  // receiver pacing: full rate, coin flip, one in four, long stalls
  always @(posedge clk) begin
    if (pace_left == 0) begin
      pace_mode = $urandom_range(0, 3);
      pace_left = $urandom_range(20, 80);
    end else begin
      pace_left = pace_left - 1;
    end
    case (pace_mode)
      0: line_out.ready <= 1'b1;
      1: line_out.ready <= 1'($urandom_range(0, 1));
      2: line_out.ready <= ($urandom_range(0, 3) == 0);
      default: line_out.ready <= (pace_left % 8 == 0);
    endcase
  end

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic apply_setting(input cfg_t s);
    write_reg(CFG_VERTICAL_TOTAL, CFG_DATA_W'(s.vertical_total));
    write_reg(CFG_VERTICAL_ADJUST, CFG_DATA_W'(s.vertical_adjust));
    write_reg(CFG_VERTICAL_DISPLAYED, CFG_DATA_W'(s.vertical_displayed));
    write_reg(CFG_VSYNC_POSITION, CFG_DATA_W'(s.vsync_position));
    write_reg(CFG_MAX_RASTER, CFG_DATA_W'(s.max_raster));
    write_reg(CFG_VSYNC_WIDTH, CFG_DATA_W'(s.vsync_width));
    write_reg(CFG_START_ADDRESS, CFG_DATA_W'(s.start_address));
    cfg_we <= 1'b0;
  endtask

  task automatic send_line(input logic [ADDR_W-1:0] end_addr);
    int unsigned gap;
    if (gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = $urandom_range(1, 8);
      line_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (burst_left > 0) burst_left--;
    line_in.valid               <= 1'b1;
    line_in.display_end_address <= end_addr;
    do @(posedge clk); while (!line_in.ready);
  endtask

  task automatic drain_lines();
    line_in.valid <= 1'b0;
    do @(posedge clk); while (lines_pending != 0);
    repeat (4) @(posedge clk);
  endtask

  function automatic int unsigned extreme_or_any(input int unsigned top);
    case ($urandom_range(0, 2))
      0: return 0;
      1: return top;
      default: return $urandom_range(0, top);
    endcase
  endfunction

  function automatic cfg_t pick_setting(input bit wide);
    cfg_t s;
    if (wide) begin
      s.vertical_total     = ROW_W'(extreme_or_any(127));
      s.vertical_adjust    = RASTER_W'(extreme_or_any(31));
      s.vertical_displayed = ROW_W'(extreme_or_any(127));
      s.vsync_position     = ROW_W'(extreme_or_any(127));
      s.max_raster         = RASTER_W'(extreme_or_any(31));
      s.vsync_width        = SYNC_W'(extreme_or_any(15));
      s.start_address      = ADDR_W'(extreme_or_any(16383));
    end else begin
      s.vertical_total     = ROW_W'($urandom_range(0, 6));
      s.max_raster         = RASTER_W'($urandom_range(0, 6));
      s.vertical_adjust    = RASTER_W'($urandom_range(0, 7));
      s.vertical_displayed = ROW_W'($urandom_range(0, s.vertical_total + 1));
      s.vsync_position     = ROW_W'($urandom_range(0, s.vertical_total + 1));
      s.vsync_width        = SYNC_W'($urandom_range(0, 15));
      s.start_address      = ADDR_W'($urandom_range(0, 16383));
    end
    return s;
  endfunction

  initial begin
    cfg_t        s;
    int unsigned n_lines;
    int unsigned phase_len;
    int unsigned settings_used;
    n_lines       = 0;
    settings_used = 0;
    gaps_on       = 1'b0;
    burst_left    = 0;
    rst_n                       <= 1'b0;
    cfg_we                      <= 1'b0;
    cfg_index                   <= CFG_VERTICAL_TOTAL;
    cfg_wdata                   <= '0;
    line_in.valid               <= 1'b0;
    line_in.display_end_address <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset registers, display stays off until the first frame restart
    send_line(14'h0000);
    send_line(14'h3fff);
    send_line(14'h2aaa);
    send_line(14'h1555);
    drain_lines();

    // adjust of 31 is never reached, sync width 0 runs 16 lines
    s = '{vertical_total: 7'd0, vertical_adjust: 5'd31, vertical_displayed: 7'd0,
          vsync_position: 7'd0, max_raster: 5'd0, vsync_width: 4'd0,
          start_address: 14'h3fff};
    apply_setting(s);
    repeat (6) send_line(ADDR_W'($urandom_range(0, 16383)));
    drain_lines();

    s = '{vertical_total: 7'd127, vertical_adjust: 5'd0, vertical_displayed: 7'd127,
          vsync_position: 7'd127, max_raster: 5'd31, vsync_width: 4'd15,
          start_address: 14'h0000};
    apply_setting(s);
    repeat (6) send_line(ADDR_W'($urandom_range(0, 16383)));
    drain_lines();

    // odd adjust and max raster with a short frame
    s = '{vertical_total: 7'd1, vertical_adjust: 5'd3, vertical_displayed: 7'd1,
          vsync_position: 7'd0, max_raster: 5'd3, vsync_width: 4'd1,
          start_address: 14'h1234};
    apply_setting(s);
    repeat (8) send_line(ADDR_W'($urandom_range(0, 16383)));
    drain_lines();
    settings_used = 4;

    while (n_lines < TARGET_LINES) begin
      gaps_on    = ($urandom_range(0, 3) != 0);
      burst_left = 0;
      s          = pick_setting($urandom_range(0, 5) == 0);
      apply_setting(s);
      phase_len = $urandom_range(30, 110);
      repeat (phase_len) send_line(ADDR_W'($urandom_range(0, 16383)));
      n_lines += phase_len;
      settings_used++;
      drain_lines();
    end

    repeat (10) @(posedge clk);
    $display("summary: %0d lines checked across %0d register settings, %0d frame ends",
             lines_checked, settings_used, frame_ends);
    if (mismatch_cnt == 0) begin
      $display("crtc_vertical_line_timing_core: match");
    end else begin
      $display("crtc_vertical_line_timing_core: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/crtc_vt_pkg.sv
sv/crtc_vt_if.sv
sv/crtc_vt_regs.sv
sv/crtc_vt_step.sv
sv/crtc_vertical_line_timing_core.sv
tb/crtc_vt_line_checker.sv
tb/testbench.sv
